>>> rtl/pwbe_pkg.sv
`timescale 1ns / 1ps

package pwbe_pkg;

  // field widths
  localparam int CMD_W       = 2;
  localparam int BYTE_W      = 8;
  localparam int TICK_W      = 16;
  localparam int BITS_LEFT_W = 4;
  localparam int DATA_W      = 32;

  // register file
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = REG_IDX_W + 2;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_PILOT_HI = 3'd0;
  localparam reg_idx_t REG_PILOT_LO = 3'd1;
  localparam reg_idx_t REG_ZERO_HI  = 3'd2;
  localparam reg_idx_t REG_ZERO_LO  = 3'd3;
  localparam reg_idx_t REG_ONE_HI   = 3'd4;
  localparam reg_idx_t REG_ONE_LO   = 3'd5;
  localparam reg_idx_t REG_FINAL_HI = 3'd6;
  localparam reg_idx_t REG_FINAL_LO = 3'd7;

  typedef logic [NUM_REGS-1:0][TICK_W-1:0] cfg_regs_t;

  // reset values, highest register first
  localparam cfg_regs_t CFG_RESET = {16'd40, 16'd10, 16'd20, 16'd30,
                                     16'd30, 16'd20, 16'd10, 16'd40};

  // command codes on the input channel
  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_TICK   = 2'd0;
  localparam cmd_t CMD_LOAD   = 2'd1;
  localparam cmd_t CMD_FINISH = 2'd2;

  // classified operations passed from front to back
  localparam int OP_W = 3;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_NOP    = 3'd0;
  localparam op_t OP_TICK   = 3'd1;
  localparam op_t OP_LOAD   = 3'd2;
  localparam op_t OP_SKIP   = 3'd3;
  localparam op_t OP_FINISH = 3'd4;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
  } q_entry_t;

endpackage

>>> rtl/pwbe_if.sv
`timescale 1ns / 1ps

// input channel: one command transaction
interface pwbe_in_if;
  import pwbe_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] data_byte;
  logic              enable;

  modport source (output valid, output cmd, output data_byte, output enable, input ready);
  modport sink   (input valid, input cmd, input data_byte, input enable, output ready);
endinterface

// result channel: line status after each transaction
interface pwbe_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic rejected;
  logic done_res;

  modport source (output valid, output line_level, output busy_res, output rejected,
                  output done_res, input ready);
  modport sink   (input valid, input line_level, input busy_res, input rejected,
                  input done_res, output ready);
endinterface

>>> rtl/pulse_width_bit_line_encoder.sv
`timescale 1ns / 1ps

// Pulse-width encoder for one output line, paced by tick transactions.
// Input channel (in_chan): cmd 0 is one tick, 1 loads data_byte (sent only when
// enable is high: pilot pulse, then eight bits LSB first, each after a low gap),
// 2 sends the closing final pulse. Loads or finishes while busy are rejected.
// Result channel (out_chan): one result per input transaction with the line
// level, busy flag, rejected flag and a done flag on the tick ending a sequence.
// Segment lengths in ticks come from eight 16-bit registers on the cfg_ port,
// register i at byte address 4*i; write them only while the block is idle.
// A transaction accepted into the queue is popped and its result registered in
// the result register. Throughput: one transaction per cycle while the receiver
// takes results, set by the single sequencer step taken per queue pop.
// A two-entry queue separates the command front from the sequencer; when the
// receiver stalls, the held result stays put, the queue fills and in_chan.ready
// drops after two more transactions.
// Reset (synchronous, rst_n low) empties the queue and result register, puts
// the sequencer idle and restores the register defaults.
module pulse_width_bit_line_encoder
  import pwbe_pkg::*;
#(
  parameter int GAP_TICKS = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  pwbe_in_if.sink           in_chan,
  pwbe_out_if.source        out_chan,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_regs_t regs;
  q_entry_t  push_entry;
  q_entry_t  head;
  logic      push;
  logic      full;
  logic      pop;
  logic      not_empty;

  // configuration registers
  pwbe_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .regs    (regs)
  );

  // command intake and classification
  pwbe_front u_front (
    .in_chan (in_chan),
    .q_full  (full),
    .q_push  (push),
    .q_entry (push_entry)
  );

  // queue between front and sequencer
  pwbe_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .not_empty  (not_empty),
    .head       (head)
  );

  // pulse sequencer and result register
  pwbe_back #(
    .GAP_TICKS (GAP_TICKS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .regs        (regs),
    .q_not_empty (not_empty),
    .q_head      (head),
    .q_pop       (pop),
    .out_chan    (out_chan)
  );

endmodule

>>> rtl/pwbe_cfg.sv
`timescale 1ns / 1ps

module pwbe_cfg
  import pwbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_regs_t         regs
);

  cfg_regs_t regs_r;
  reg_idx_t  idx;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign regs   = regs_r;

  // register write in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= CFG_RESET;
    end else if (psel && penable && pwrite) begin
      regs_r[idx] <= pwdata[TICK_W-1:0];
    end
  end

  // read back, upper half zero
  assign prdata = {{(DATA_W-TICK_W){1'b0}}, regs_r[idx]};

endmodule

>>> rtl/pwbe_front.sv
`timescale 1ns / 1ps

module pwbe_front
  import pwbe_pkg::*;
(
  pwbe_in_if.sink  in_chan,
  input  logic     q_full,
  output logic     q_push,
  output q_entry_t q_entry
);

  assign in_chan.ready = !q_full;
  assign q_push        = in_chan.valid && !q_full;

  // classify the command; a load with enable low becomes a skip
  always_comb begin
    q_entry.data = in_chan.data_byte;
    case (in_chan.cmd)
      CMD_TICK:   q_entry.op = OP_TICK;
      CMD_LOAD:   q_entry.op = in_chan.enable ? OP_LOAD : OP_SKIP;
      CMD_FINISH: q_entry.op = OP_FINISH;
      default:    q_entry.op = OP_NOP;
    endcase
  end

endmodule

>>> rtl/pwbe_fifo.sv
`timescale 1ns / 1ps

module pwbe_fifo
  import pwbe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output q_entry_t head
);

  localparam int DEPTH = 2;

  q_entry_t   mem_r [DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full      = (count_r == 2'(DEPTH));
  assign not_empty = (count_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(DEPTH))
    else $error("queue fill level beyond depth");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("pointers disagree with fill level");

endmodule

>>> rtl/pwbe_back.sv
`timescale 1ns / 1ps

module pwbe_back
  import pwbe_pkg::*;
#(
  parameter int GAP_TICKS = 1
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t regs,
  input  logic      q_not_empty,
  input  q_entry_t  q_head,
  output logic      q_pop,
  pwbe_out_if.source out_chan
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_PILOT_HI = 3'd1;
  localparam logic [2:0] PH_PILOT_LO = 3'd2;
  localparam logic [2:0] PH_GAP      = 3'd3;
  localparam logic [2:0] PH_BIT_HI   = 3'd4;
  localparam logic [2:0] PH_BIT_LO   = 3'd5;
  localparam logic [2:0] PH_FINAL_HI = 3'd6;
  localparam logic [2:0] PH_FINAL_LO = 3'd7;

  localparam logic              GAP_EN   = (GAP_TICKS > 0);
  localparam logic [TICK_W-1:0] GAP_LOAD = TICK_W'(GAP_TICKS);

  logic [2:0]             phase_r, phase_nxt;
  logic [TICK_W-1:0]      tick_r, tick_nxt;
  logic [BYTE_W-1:0]      shift_r, shift_nxt;
  logic [BITS_LEFT_W-1:0] bits_left_r, bits_left_nxt;
  logic                   busy;
  logic                   rej;
  logic                   done;

  logic out_valid_r;
  logic line_r, busy_r, rej_r, done_r;

  assign busy  = (phase_r != PH_IDLE);
  assign q_pop = q_not_empty && (!out_valid_r || out_chan.ready);

  // sequencer step for the transaction at the queue head
  always_comb begin
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    shift_nxt     = shift_r;
    bits_left_nxt = bits_left_r;
    rej           = 1'b0;
    done          = 1'b0;
    case (q_head.op)
      OP_TICK: begin
        if (busy) begin
          if (tick_r > TICK_W'(1)) begin
            tick_nxt = tick_r - TICK_W'(1);
          end else begin
            case (phase_r)
              PH_PILOT_HI: begin
                phase_nxt = PH_PILOT_LO;
                tick_nxt  = regs[REG_PILOT_LO];
              end
              PH_PILOT_LO: begin
                if (GAP_EN) begin
                  phase_nxt = PH_GAP;
                  tick_nxt  = GAP_LOAD;
                end else begin
                  phase_nxt = PH_BIT_HI;
                  tick_nxt  = shift_r[0] ? regs[REG_ONE_HI] : regs[REG_ZERO_HI];
                end
              end
              PH_GAP: begin
                phase_nxt = PH_BIT_HI;
                tick_nxt  = shift_r[0] ? regs[REG_ONE_HI] : regs[REG_ZERO_HI];
              end
              PH_BIT_HI: begin
                phase_nxt = PH_BIT_LO;
                tick_nxt  = shift_r[0] ? regs[REG_ONE_LO] : regs[REG_ZERO_LO];
              end
              PH_BIT_LO: begin
                shift_nxt     = shift_r >> 1;
                bits_left_nxt = bits_left_r - BITS_LEFT_W'(1);
                if (bits_left_r == BITS_LEFT_W'(1)) begin
                  phase_nxt = PH_IDLE;
                  tick_nxt  = '0;
                  done      = 1'b1;
                end else if (GAP_EN) begin
                  phase_nxt = PH_GAP;
                  tick_nxt  = GAP_LOAD;
                end else begin
                  // next bit is the one shifted down into place
                  phase_nxt = PH_BIT_HI;
                  tick_nxt  = shift_r[1] ? regs[REG_ONE_HI] : regs[REG_ZERO_HI];
                end
              end
              PH_FINAL_HI: begin
                phase_nxt = PH_FINAL_LO;
                tick_nxt  = regs[REG_FINAL_LO];
              end
              default: begin
                phase_nxt = PH_IDLE;
                tick_nxt  = '0;
                done      = 1'b1;
              end
            endcase
          end
        end
      end
      OP_LOAD: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          shift_nxt     = q_head.data;
          bits_left_nxt = BITS_LEFT_W'(BYTE_W);
          phase_nxt     = PH_PILOT_HI;
          tick_nxt      = regs[REG_PILOT_HI];
        end
      end
      OP_SKIP: begin
        rej = busy;
      end
      OP_FINISH: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          phase_nxt = PH_FINAL_HI;
          tick_nxt  = regs[REG_FINAL_HI];
        end
      end
      default: begin
        rej = 1'b0;
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      shift_r     <= '0;
      bits_left_r <= '0;
    end else if (q_pop) begin
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      shift_r     <= shift_nxt;
      bits_left_r <= bits_left_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= q_pop || (out_valid_r && !out_chan.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      line_r <= (phase_nxt == PH_PILOT_HI) || (phase_nxt == PH_BIT_HI) ||
                (phase_nxt == PH_FINAL_HI);
      busy_r <= (phase_nxt != PH_IDLE);
      rej_r  <= rej;
      done_r <= done;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.line_level = line_r;
  assign out_chan.busy_res   = busy_r;
  assign out_chan.rejected   = rej_r;
  assign out_chan.done_res   = done_r;

  a_bits_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_GAP || phase_r == PH_BIT_HI || phase_r == PH_BIT_LO)
      |-> (bits_left_r != '0))
    else $error("bit phase with no bits left");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> (!busy_r && !line_r && !rej_r))
    else $error("done result while still busy");

  a_idle_line_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !busy_r) |-> !line_r)
    else $error("line high while idle");

  a_pop_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r)
    else $error("popped transaction left no result");

endmodule
